/* src/scb_pkg.sv */
// ----------------------------------------------------------------------------
// scb_pkg
// Shared types and constants for the SIMON block cipher: request codes,
// status codes, controller command bundle and the round-constant sequences.
// ----------------------------------------------------------------------------
package scb_pkg;

   // width of every data word on the channels
   localparam int IO_BITS = 32;

   // length of one round-constant sequence
   localparam int SEQ_LEN = 62;

   // request command codes
   typedef enum logic [1:0] {
      OP_KEY  = 2'd0,
      OP_ENC  = 2'd1,
      OP_DEC  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_DATA  = 2'd0,
      ST_KEY   = 2'd1,
      ST_NOKEY = 2'd2
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       load_key;    // take key words into the expansion window
      logic       load_blk;    // take data blocks into the round lanes
      logic       key_step;    // write one round key, advance the window
      logic       round_step;  // run one round on both lanes
      logic       out_load;    // capture the response payload
      logic       decrypt;     // current item is a decryption
      status_type kind;        // status of the response being captured
   } ctl_cmd_type;

   // round-constant sequences z0..z4, index 0 is used first
   localparam logic [0:SEQ_LEN-1] Z_SEQ [5] = '{
      62'b11111010001001010110000111001101111101000100101011000011100110,
      62'b10001110111110010011000010110101000111011111001001100001011010,
      62'b10101111011100000011010010011000101000010001111110010110110011,
      62'b11011011101011000110010111100000010010001010011100110100001111,
      62'b11010001111001101011011000100000010111000011001010010011101111
   };

endpackage

/* src/scb_if.sv */
// ----------------------------------------------------------------------------
// scb_req_if / scb_rsp_if
// Valid/ready channels carrying cipher requests and responses.
// ----------------------------------------------------------------------------
interface scb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] word0;
   logic [31:0] word1;
   logic [31:0] word2;
   logic [31:0] word3;
   logic        two_blocks;

   modport source (output valid, output cmd, output word0, output word1,
                   output word2, output word3, output two_blocks, input ready);
   modport sink   (input valid, input cmd, input word0, input word1,
                   input word2, input word3, input two_blocks, output ready);
endinterface

interface scb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out0;
   logic [31:0] out1;
   logic [31:0] out2;
   logic [31:0] out3;
   logic [1:0]  status;

   modport source (output valid, output out0, output out1, output out2,
                   output out3, output status, input ready);
   modport sink   (input valid, input out0, input out1, input out2,
                   input out3, input status, output ready);
endinterface

/* src/scb_dpath.sv */
// ----------------------------------------------------------------------------
// scb_dpath
// Cipher datapath: key expansion window, round-key memory, two round lanes
// sharing one key per cycle, and the response register.
// ----------------------------------------------------------------------------
module scb_dpath #(
   parameter int WORD_BITS       = 32,
   parameter int KEY_WORDS       = 4,
   parameter int ROUNDS          = 44,
   parameter int SEQUENCE_SELECT = 3,
   localparam int AddrBits       = $clog2(ROUNDS)
) (
   input  logic                        clock,
   input  scb_pkg::ctl_cmd_type        cmd,
   input  logic [AddrBits-1:0]         mem_addr,
   input  logic [scb_pkg::IO_BITS-1:0] req_word0,
   input  logic [scb_pkg::IO_BITS-1:0] req_word1,
   input  logic [scb_pkg::IO_BITS-1:0] req_word2,
   input  logic [scb_pkg::IO_BITS-1:0] req_word3,
   input  logic                        req_two_blocks,
   output logic [scb_pkg::IO_BITS-1:0] rsp_out0,
   output logic [scb_pkg::IO_BITS-1:0] rsp_out1,
   output logic [scb_pkg::IO_BITS-1:0] rsp_out2,
   output logic [scb_pkg::IO_BITS-1:0] rsp_out3,
   output logic [1:0]                  rsp_status
);

   localparam int ZSel     = SEQUENCE_SELECT % 5;
   localparam int ZIdxBits = $clog2(scb_pkg::SEQ_LEN);

   typedef logic [WORD_BITS-1:0]        word_type;
   typedef logic [scb_pkg::IO_BITS-1:0] io_word_type;

   function automatic word_type rotl(input word_type v, input int r);
      rotl = (v << r) | (v >> (WORD_BITS - r));
   endfunction

   function automatic word_type rotr(input word_type v, input int r);
      rotr = (v >> r) | (v << (WORD_BITS - r));
   endfunction

   function automatic word_type mix(input word_type v);
      mix = (rotl(v, 1) & rotl(v, 8)) ^ rotl(v, 2);
   endfunction

   function automatic io_word_type to_io(input word_type w);
      to_io = scb_pkg::IO_BITS'(w);
   endfunction

   word_type            kw_ff [KEY_WORDS];
   word_type            kw_in [KEY_WORDS];
   word_type            kin   [4];
   word_type            new_key;
   logic [ZIdxBits-1:0] zidx_ff;
   logic [ZIdxBits-1:0] zidx_in;

   word_type            rk_mem [ROUNDS];
   word_type            key_ff;

   word_type            x0_ff, y0_ff, x1_ff, y1_ff;
   word_type            x0_in, y0_in, x1_in, y1_in;
   logic                two_ff, two_in;

   io_word_type         out0_ff, out1_ff, out2_ff, out3_ff;
   io_word_type         out0_in, out1_in, out2_in, out3_in;
   scb_pkg::status_type status_ff, status_in;

   // key words in schedule order, k0 comes from word3
   assign kin[0] = WORD_BITS'(req_word3);
   assign kin[1] = WORD_BITS'(req_word2);
   assign kin[2] = WORD_BITS'(req_word1);
   assign kin[3] = WORD_BITS'(req_word0);

   // next round key from the window of the last KEY_WORDS keys
   always_comb begin
      word_type t;
      t = rotr(kw_ff[KEY_WORDS-1], 3);
      if (KEY_WORDS == 4) begin
         t = t ^ kw_ff[1];
      end
      t = t ^ rotr(t, 1);
      t = t ^ ~kw_ff[0];
      t = t ^ WORD_BITS'(scb_pkg::Z_SEQ[ZSel][zidx_ff]);
      t = t ^ WORD_BITS'(3);
      new_key = t;
   end

   // expansion window and sequence index
   always_comb begin
      kw_in   = kw_ff;
      zidx_in = zidx_ff;
      if (cmd.load_key) begin
         for (int j = 0; j < KEY_WORDS; j++) begin
            kw_in[j] = kin[j];
         end
         zidx_in = '0;
      end else if (cmd.key_step) begin
         for (int j = 0; j < KEY_WORDS - 1; j++) begin
            kw_in[j] = kw_ff[j+1];
         end
         kw_in[KEY_WORDS-1] = new_key;
         zidx_in = (zidx_ff == ZIdxBits'(scb_pkg::SEQ_LEN - 1)) ? '0 : zidx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      kw_ff   <= kw_in;
      zidx_ff <= zidx_in;
   end

   // round-key memory, oldest window entry is the key for this address
   always_ff @(posedge clock) begin
      if (cmd.key_step) begin
         rk_mem[mem_addr] <= kw_ff[0];
      end
      key_ff <= rk_mem[mem_addr];
   end

   // two round lanes sharing the round key
   always_comb begin
      x0_in  = x0_ff;
      y0_in  = y0_ff;
      x1_in  = x1_ff;
      y1_in  = y1_ff;
      two_in = two_ff;
      if (cmd.load_blk) begin
         x0_in  = cmd.decrypt ? WORD_BITS'(req_word1) : WORD_BITS'(req_word0);
         y0_in  = cmd.decrypt ? WORD_BITS'(req_word0) : WORD_BITS'(req_word1);
         x1_in  = cmd.decrypt ? WORD_BITS'(req_word3) : WORD_BITS'(req_word2);
         y1_in  = cmd.decrypt ? WORD_BITS'(req_word2) : WORD_BITS'(req_word3);
         two_in = req_two_blocks;
      end else if (cmd.round_step) begin
         x0_in = y0_ff ^ mix(x0_ff) ^ key_ff;
         y0_in = x0_ff;
         x1_in = y1_ff ^ mix(x1_ff) ^ key_ff;
         y1_in = x1_ff;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff  <= x0_in;
      y0_ff  <= y0_in;
      x1_ff  <= x1_in;
      y1_ff  <= y1_in;
      two_ff <= two_in;
   end

   // response payload, halves swapped back after decryption
   always_comb begin
      out0_in   = out0_ff;
      out1_in   = out1_ff;
      out2_in   = out2_ff;
      out3_in   = out3_ff;
      status_in = status_ff;
      if (cmd.out_load) begin
         status_in = cmd.kind;
         out0_in   = '0;
         out1_in   = '0;
         out2_in   = '0;
         out3_in   = '0;
         if (cmd.kind == scb_pkg::ST_DATA) begin
            out0_in = cmd.decrypt ? to_io(y0_ff) : to_io(x0_ff);
            out1_in = cmd.decrypt ? to_io(x0_ff) : to_io(y0_ff);
            if (two_ff) begin
               out2_in = cmd.decrypt ? to_io(y1_ff) : to_io(x1_ff);
               out3_in = cmd.decrypt ? to_io(x1_ff) : to_io(y1_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out0_ff   <= out0_in;
      out1_ff   <= out1_in;
      out2_ff   <= out2_in;
      out3_ff   <= out3_in;
      status_ff <= status_in;
   end

   assign rsp_out0   = out0_ff;
   assign rsp_out1   = out1_ff;
   assign rsp_out2   = out2_ff;
   assign rsp_out3   = out3_ff;
   assign rsp_status = 2'(status_ff);

endmodule

/* src/scb_ctrl.sv */
// ----------------------------------------------------------------------------
// scb_ctrl
// Cipher controller: sequences key expansion and rounds, addresses the
// round-key memory and runs the request and response handshakes.
// ----------------------------------------------------------------------------
module scb_ctrl #(
   parameter int ROUNDS     = 44,
   localparam int AddrBits  = $clog2(ROUNDS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_cmd,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output scb_pkg::ctl_cmd_type cmd,
   output logic [AddrBits-1:0]  mem_addr
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_KEY   = 5'b00010,
      S_FETCH = 5'b00100,
      S_ROUND = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [AddrBits-1:0] cnt_ff, cnt_in;
   logic                dec_ff, dec_in;
   logic                key_ready_ff, key_ready_in;
   logic                rsp_valid_ff, rsp_valid_in;
   scb_pkg::status_type kind_ff, kind_in;

   logic                accept;
   logic                last;
   logic                out_load;
   logic [AddrBits:0]   ridx;
   logic [AddrBits-1:0] rd_idx;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign last      = (cnt_ff == AddrBits'(ROUNDS - 1));
   assign out_load  = (state_ff == S_DONE) & (~rsp_valid_ff | rsp_ready);

   // round-key index to prefetch, one round ahead of the lanes
   always_comb begin
      ridx = (state_ff == S_FETCH) ? '0 : {1'b0, cnt_ff} + 1'b1;
      if (ridx >= (AddrBits + 1)'(ROUNDS)) begin
         ridx = '0;
      end
      rd_idx = ridx[AddrBits-1:0];
   end

   // key expansion writes in order, crypt reads forward or backward
   always_comb begin
      if (state_ff == S_KEY) begin
         mem_addr = cnt_ff;
      end else if (dec_ff) begin
         mem_addr = AddrBits'(ROUNDS - 1) - rd_idx;
      end else begin
         mem_addr = rd_idx;
      end
   end

   // next state and counters
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dec_in       = dec_ff;
      key_ready_in = key_ready_ff;
      kind_in      = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cnt_in = '0;
               unique case (scb_pkg::op_type'(req_cmd))
                  scb_pkg::OP_KEY: begin
                     state_in = S_KEY;
                  end
                  scb_pkg::OP_ENC, scb_pkg::OP_DEC: begin
                     dec_in = (scb_pkg::op_type'(req_cmd) == scb_pkg::OP_DEC);
                     if (key_ready_ff) begin
                        state_in = S_FETCH;
                     end else begin
                        kind_in  = scb_pkg::ST_NOKEY;
                        state_in = S_DONE;
                     end
                  end
                  scb_pkg::OP_NONE: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_KEY: begin
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               key_ready_in = 1'b1;
               kind_in      = scb_pkg::ST_KEY;
               state_in     = S_DONE;
            end
         end
         S_FETCH: begin
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               kind_in  = scb_pkg::ST_DATA;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid holds until taken
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         dec_ff       <= 1'b0;
         key_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= scb_pkg::ST_DATA;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dec_ff       <= dec_in;
         key_ready_ff <= key_ready_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
      end
   end

   // datapath commands
   always_comb begin
      cmd.load_key   = accept & (scb_pkg::op_type'(req_cmd) == scb_pkg::OP_KEY);
      cmd.load_blk   = accept & key_ready_ff &
                       ((scb_pkg::op_type'(req_cmd) == scb_pkg::OP_ENC) ||
                        (scb_pkg::op_type'(req_cmd) == scb_pkg::OP_DEC));
      cmd.key_step   = (state_ff == S_KEY);
      cmd.round_step = (state_ff == S_ROUND);
      cmd.out_load   = out_load;
      cmd.decrypt    = (state_ff == S_IDLE) ?
                       (scb_pkg::op_type'(req_cmd) == scb_pkg::OP_DEC) : dec_ff;
      cmd.kind       = kind_ff;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* src/simon_block_cipher.sv */
// ----------------------------------------------------------------------------
// simon_block_cipher
// SIMON block cipher (64/128 by default) with a stored round-key schedule.
// ----------------------------------------------------------------------------
// One request at a time. A key-load request expands the key words into the
// round-key memory at one key per cycle and answers with status "key loaded".
// An encrypt or decrypt request takes one or two blocks through the two round
// lanes, one round per cycle with the key read one round ahead from the
// single-port round-key memory into a register, and answers as soon for two
// blocks as for one. Without a loaded key a data request answers zeros with
// status "refused". Command code 3 is taken and dropped. The response waits
// in an output register; the block takes no new request until its response
// is in that register and the previous one has been taken.
module simon_block_cipher #(
   parameter int WORD_BITS       = 32,
   parameter int KEY_WORDS       = 4,
   parameter int ROUNDS          = 44,
   parameter int SEQUENCE_SELECT = 3
) (
   input  logic   clock,
   input  logic   reset,
   scb_req_if.sink   req_ch,
   scb_rsp_if.source rsp_ch
);

   localparam int AddrBits = $clog2(ROUNDS);

   scb_pkg::ctl_cmd_type cmd;
   logic [AddrBits-1:0]  mem_addr;

   // sequencing and handshakes
   scb_ctrl #(
      .ROUNDS (ROUNDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd),
      .mem_addr  (mem_addr)
   );

   // key schedule, round lanes and response register
   scb_dpath #(
      .WORD_BITS       (WORD_BITS),
      .KEY_WORDS       (KEY_WORDS),
      .ROUNDS          (ROUNDS),
      .SEQUENCE_SELECT (SEQUENCE_SELECT)
   ) u_dpath (
      .clock          (clock),
      .cmd            (cmd),
      .mem_addr       (mem_addr),
      .req_word0      (req_ch.word0),
      .req_word1      (req_ch.word1),
      .req_word2      (req_ch.word2),
      .req_word3      (req_ch.word3),
      .req_two_blocks (req_ch.two_blocks),
      .rsp_out0       (rsp_ch.out0),
      .rsp_out1       (rsp_ch.out1),
      .rsp_out2       (rsp_ch.out2),
      .rsp_out3       (rsp_ch.out3),
      .rsp_status     (rsp_ch.status)
   );

endmodule
